// File: rtl/core/utf8v_pkg.sv
// Shared types, constants and decode helpers for the UTF-8 stream validator.
`timescale 1ns / 1ps

package utf8v_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int OUT_COUNT_W     = 32;

    localparam logic [7:0] LEAD_C0 = 8'hC0;
    localparam logic [7:0] LEAD_C1 = 8'hC1;
    localparam logic [7:0] LEAD_FE = 8'hFE;

    localparam logic [5:0] OVL_MASK_3B = 6'h20;
    localparam logic [5:0] OVL_MASK_4B = 6'h30;
    localparam logic [5:0] OVL_MASK_5B = 6'h38;
    localparam logic [5:0] OVL_MASK_6B = 6'h3C;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_STRAY    = 3'd1,
        ERR_BAD_LEAD = 3'd2,
        ERR_MISSING  = 3'd3,
        ERR_OVERLONG = 3'd4,
        ERR_TRUNC    = 3'd5
    } t_err;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       is_last;
    } t_in_word;

    typedef struct packed {
        logic [2:0]             error_code;
        logic                   sequence_open;
        logic [OUT_COUNT_W-1:0] codepoint_count;
        logic                   string_done;
    } t_out_word;

    typedef struct packed {
        logic       is_cont;
        logic       bad_lead;
        logic       long_form;
        logic [2:0] cont_left;
        logic [5:0] ovl_mask;
    } t_lead;

    typedef struct packed {
        logic [2:0] expect_cnt;
        logic [5:0] ovl_mask;
        t_err       err;
    } t_state;

    function automatic logic [5:0] f_ovl_mask(input logic [2:0] cont_left);
        logic [5:0] m;
        begin
            unique case (cont_left)
                3'd2:    m = OVL_MASK_3B;
                3'd3:    m = OVL_MASK_4B;
                3'd4:    m = OVL_MASK_5B;
                3'd5:    m = OVL_MASK_6B;
                default: m = 6'h00;
            endcase
            return m;
        end
    endfunction

endpackage

// File: rtl/core/utf8_stream_validator.sv
// UTF-8 stream validator: input and result registers around the byte decode and state update.
// Usage:
//   Input channel i_in_valid / o_in_ready carries one word per string byte:
//   the byte and a last marker. Output channel o_out_valid / i_out_ready
//   returns one word per input word: sticky error code, open-sequence flag,
//   running code point count (saturating at COUNT_WIDTH bits, shown as 32)
//   and a done flag on the word for the last byte.
//   i_cfg_we / i_cfg_wdata write allow_long_forms; write it only when idle.
//   An accepted word is held in the input register, decoded out of it, and
//   its result is loaded into the result register.
//   Throughput: one word per cycle when the output is not stalled; the decode and update
//   between the input register and the result register are combinational.
//   Reset (synchronous, active low) empties both registers, clears the
//   decoder state and count, and sets allow_long_forms to 1.
//   A stall on the output holds the result register; the input register
//   still takes one more word, then o_in_ready drops until the result moves.
//   After a last byte all decoder state and the count return to zero.
`timescale 1ns / 1ps

module utf8_stream_validator
    import utf8v_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);

    logic                   r_in_valid;
    t_in_word               r_in_word;
    logic                   r_out_valid;
    t_out_word              r_out_word;
    logic                   r_allow_long;
    t_state                 r_state;
    logic [COUNT_WIDTH-1:0] r_count;

    t_state                 n_state;
    logic [COUNT_WIDTH-1:0] n_count;
    t_out_word              n_out_word;
    logic                   adv;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    utf8v_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_word       (r_in_word),
        .i_allow_long (r_allow_long),
        .i_state      (r_state),
        .i_count      (r_count),
        .o_state      (n_state),
        .o_count      (n_count),
        .o_result     (n_out_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_allow_long <= 1'b1;
            r_state      <= '{expect_cnt: 3'd0, ovl_mask: 6'h00, err: ERR_NONE};
            r_count      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_allow_long <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (adv) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_word.is_last |=>
            r_state.expect_cnt == 3'd0 && r_state.err == ERR_NONE && r_count == '0)
        else $error("decoder state not cleared after last byte");

    a_mask_needs_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.ovl_mask != 6'h00 |-> r_state.expect_cnt != 3'd0)
        else $error("overlong check pending with no open sequence");

    a_expect_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.expect_cnt <= 3'd5)
        else $error("continuation count out of range");

    a_error_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !r_in_word.is_last && r_state.err != ERR_NONE |=>
            r_state.err == $past(r_state.err))
        else $error("sticky error replaced");

    a_open_at_end_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_word.string_done && r_out_word.sequence_open |->
            r_out_word.error_code != ERR_NONE)
        else $error("open sequence at last byte reported as ok");

endmodule

// File: rtl/core/utf8v_lead_decode.sv
// Lead byte decode: sequence length, reject flags and overlong mask.
`timescale 1ns / 1ps

module utf8v_lead_decode
    import utf8v_pkg::*;
(
    input  logic [7:0] i_byte,
    output t_lead      o_lead
);

    logic [2:0] cont_left;
    logic [7:0] pay_mask;
    logic       pay_zero;

    always_comb begin
        priority if (i_byte < 8'hC0) begin
            cont_left = 3'd0;
        end else if (i_byte < 8'hE0) begin
            cont_left = 3'd1;
        end else if (i_byte < 8'hF0) begin
            cont_left = 3'd2;
        end else if (i_byte < 8'hF8) begin
            cont_left = 3'd3;
        end else if (i_byte < 8'hFC) begin
            cont_left = 3'd4;
        end else if (i_byte < LEAD_FE) begin
            cont_left = 3'd5;
        end else begin
            cont_left = 3'd0;
        end
    end

    assign pay_mask = 8'h7F >> (cont_left + 3'd1);
    assign pay_zero = (i_byte & pay_mask) == 8'h00;

    always_comb begin
        o_lead.is_cont   = i_byte[7:6] == 2'b10;
        o_lead.bad_lead  = (i_byte >= LEAD_FE) || (i_byte == LEAD_C0) || (i_byte == LEAD_C1);
        o_lead.long_form = cont_left >= 3'd4;
        o_lead.cont_left = cont_left;
        o_lead.ovl_mask  = pay_zero ? f_ovl_mask(cont_left) : 6'h00;
    end

endmodule

// File: rtl/core/utf8v_step.sv
// Per-word state update: continuation check, lead handling, count and verdict.
`timescale 1ns / 1ps

module utf8v_step
    import utf8v_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  t_in_word               i_word,
    input  logic                   i_allow_long,
    input  t_state                 i_state,
    input  logic [COUNT_WIDTH-1:0] i_count,
    output t_state                 o_state,
    output logic [COUNT_WIDTH-1:0] o_count,
    output t_out_word              o_result
);

    t_lead                  lead;
    t_err                   cand;
    t_err                   err;
    logic [2:0]             n_expect;
    logic [5:0]             n_mask;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   open;

    utf8v_lead_decode u_lead_decode (
        .i_byte (i_word.byte_value),
        .o_lead (lead)
    );

    always_comb begin
        cand     = ERR_NONE;
        n_mask   = 6'h00;
        n_expect = i_state.expect_cnt;
        n_count  = i_count;
        if (i_state.expect_cnt != 3'd0) begin
            n_expect = i_state.expect_cnt - 3'd1;
            priority if (!lead.is_cont) begin
                cand = ERR_MISSING;
            end else if ((i_state.ovl_mask != 6'h00) &&
                         ((i_word.byte_value[5:0] & i_state.ovl_mask) == 6'h00)) begin
                cand = ERR_OVERLONG;
            end else begin
                cand = ERR_NONE;
            end
        end else begin
            n_expect = lead.cont_left;
            n_count  = (i_count == '1) ? i_count : i_count + COUNT_WIDTH'(1);
            priority if (lead.is_cont) begin
                cand = ERR_STRAY;
            end else if (lead.bad_lead) begin
                cand = ERR_BAD_LEAD;
            end else if (lead.long_form && !i_allow_long) begin
                cand = ERR_BAD_LEAD;
            end else begin
                n_mask = lead.ovl_mask;
            end
        end
    end

    assign open = n_expect != 3'd0;

    always_comb begin
        priority if (i_state.err != ERR_NONE) begin
            err = i_state.err;
        end else if (cand != ERR_NONE) begin
            err = cand;
        end else if (i_word.is_last && open) begin
            err = ERR_TRUNC;
        end else begin
            err = ERR_NONE;
        end
    end

    always_comb begin
        o_result.error_code      = err;
        o_result.sequence_open   = open;
        o_result.codepoint_count = OUT_COUNT_W'(n_count);
        o_result.string_done     = i_word.is_last;
        if (i_word.is_last) begin
            o_state.expect_cnt = 3'd0;
            o_state.ovl_mask   = 6'h00;
            o_state.err        = ERR_NONE;
            o_count            = '0;
        end else begin
            o_state.expect_cnt = n_expect;
            o_state.ovl_mask   = n_mask;
            o_state.err        = err;
            o_count            = n_count;
        end
    end

endmodule
